/* rtl/rodes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rodes_pkg
// Shared widths, types and helper functions for the rod element stiffness
// pipeline.
// ----------------------------------------------------------------------------
package rodes_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LEN_FRAC  = 16;
  localparam int SH        = FRAC_BITS + LEN_FRAC;

  localparam int ID_W  = 16;
  localparam int CRD_W = 32;
  localparam int AX_W  = CRD_W + 1;
  localparam int U_W   = 2 * AX_W;
  localparam int S_W   = U_W + 1;
  localparam int X_W   = S_W + 2 * LEN_FRAC;
  localparam int SQ_W  = (X_W + 1) / 2;
  localparam int D_W   = S_W + SQ_W;
  localparam int EA_W  = 2 * CRD_W;
  localparam int N_W   = EA_W + U_W;
  localparam int NF_W  = N_W + SH;
  localparam int QB    = 64;
  localparam int REM_W = D_W + 1;
  localparam int HI_W  = NF_W - QB;

  localparam int NL     = 3;
  localparam int LN_CC  = 0;
  localparam int LN_CS  = 1;
  localparam int LN_SS  = 2;

  localparam int LIMB = 32;
  localparam int PA_L = 3;
  localparam int PB_L = 2;
  localparam int PA_W = PA_L * LIMB;
  localparam int PB_W = PB_L * LIMB;
  localparam int PS_W = PA_W + PB_W;

  localparam logic [QB-1:0] POS_LIM = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] NEG_LIM = {1'b1, {(QB-1){1'b0}}};

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            zero;
    logic            neg;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [S_W-1:0]   s;
    logic [U_W-1:0]   xx;
    logic [U_W-1:0]   yy;
    logic [U_W-1:0]   xy;
    logic [EA_W-1:0]  ea;
  } sqp_t;

  typedef logic [PA_L*PB_L-1:0][2*LIMB-1:0] pp_t;
  typedef logic [NL-1:0][N_W-1:0]           num_t;
  typedef logic [NL-1:0][QB-1:0]            quo_t;

  // limb partial products, each one 32x32
  function automatic pp_t pp_mul(input logic [PA_W-1:0] a, input logic [PB_W-1:0] b);
    pp_t p;
    for (int i = 0; i < PA_L; i++) begin
      for (int j = 0; j < PB_L; j++) begin
        p[i*PB_L+j] = a[i*LIMB +: LIMB] * b[j*LIMB +: LIMB];
      end
    end
    return p;
  endfunction

  function automatic logic [PS_W-1:0] pp_sum(input pp_t p);
    logic [PS_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < PA_L; i++) begin
      for (int j = 0; j < PB_L; j++) begin
        acc = acc + ({{(PS_W-2*LIMB){1'b0}}, p[i*PB_L+j]} << ((i + j) * LIMB));
      end
    end
    return acc;
  endfunction

endpackage

/* rtl/rodes_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rodes_div
// Three-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage, with an overflow precheck stage in front.
// ----------------------------------------------------------------------------
module rodes_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  rodes_pkg::side_t            in_side,
  input  logic [rodes_pkg::D_W-1:0]   in_d,
  input  rodes_pkg::num_t             in_num,
  output logic                        out_valid,
  output rodes_pkg::side_t            out_side,
  output rodes_pkg::quo_t             out_quo,
  output logic [rodes_pkg::NL-1:0]    out_ovf
);

  localparam int QB    = rodes_pkg::QB;
  localparam int NL    = rodes_pkg::NL;
  localparam int D_W   = rodes_pkg::D_W;
  localparam int REM_W = rodes_pkg::REM_W;
  localparam int NF_W  = rodes_pkg::NF_W;
  localparam int HI_W  = rodes_pkg::HI_W;
  localparam int SH    = rodes_pkg::SH;

  logic                   v_r      [QB+1];
  logic                   v_nxt    [QB+1];
  rodes_pkg::side_t       side_r   [QB+1];
  rodes_pkg::side_t       side_nxt [QB+1];
  logic [D_W-1:0]         d_r      [QB+1];
  logic [D_W-1:0]         d_nxt    [QB+1];
  logic [NL-1:0]          ovf_r    [QB+1];
  logic [NL-1:0]          ovf_nxt  [QB+1];
  logic [REM_W-1:0]       rem_r    [QB+1][NL];
  logic [REM_W-1:0]       rem_nxt  [QB+1][NL];
  logic [QB-1:0]          lo_r     [QB+1][NL];
  logic [QB-1:0]          lo_nxt   [QB+1][NL];
  logic [QB-1:0]          q_r      [QB+1][NL];
  logic [QB-1:0]          q_nxt    [QB+1][NL];

  assign v_nxt[0]    = in_valid;
  assign side_nxt[0] = in_side;
  assign d_nxt[0]    = in_d;

  // precheck: quotient of 2^64 or more
  for (genvar l = 0; l < NL; l++) begin : g_pre
    logic [NF_W-1:0] nf;
    logic [HI_W-1:0] hi;
    assign nf              = {in_num[l], {SH{1'b0}}};
    assign hi              = nf[NF_W-1:QB];
    assign ovf_nxt[0][l]   = {{(REM_W-HI_W){1'b0}}, hi} >= {1'b0, in_d};
    assign rem_nxt[0][l]   = {{(REM_W-HI_W){1'b0}}, hi};
    assign lo_nxt[0][l]    = nf[QB-1:0];
    assign q_nxt[0][l]     = '0;
  end

  for (genvar j = 0; j < QB; j++) begin : g_stage
    assign v_nxt[j+1]    = v_r[j];
    assign side_nxt[j+1] = side_r[j];
    assign d_nxt[j+1]    = d_r[j];
    assign ovf_nxt[j+1]  = ovf_r[j];
    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [REM_W-1:0] t;
      logic             ge;
      assign t                = {rem_r[j][l][REM_W-2:0], lo_r[j][l][QB-1]};
      assign ge               = t >= {1'b0, d_r[j]};
      assign rem_nxt[j+1][l]  = ge ? (t - {1'b0, d_r[j]}) : t;
      assign q_nxt[j+1][l]    = {q_r[j][l][QB-2:0], ge};
      assign lo_nxt[j+1][l]   = {lo_r[j][l][QB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QB; j++) v_r[j] <= 1'b0;
    end else begin
      for (int j = 0; j <= QB; j++) v_r[j] <= v_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j <= QB; j++) begin
      side_r[j] <= side_nxt[j];
      d_r[j]    <= d_nxt[j];
      ovf_r[j]  <= ovf_nxt[j];
      for (int l = 0; l < NL; l++) begin
        rem_r[j][l] <= rem_nxt[j][l];
        lo_r[j][l]  <= lo_nxt[j][l];
        q_r[j][l]   <= q_nxt[j][l];
      end
    end
  end

  assign out_valid = v_r[QB];
  assign out_side  = side_r[QB];
  assign out_ovf   = ovf_r[QB];
  for (genvar l = 0; l < NL; l++) begin : g_out
    assign out_quo[l] = q_r[QB][l];
  end

  a_zero_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && side_r[0].zero |-> &ovf_r[0])
    else $error("zero divisor not flagged as overflow");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[QB] |-> (ovf_r[QB][0] || rem_r[QB][0] < {1'b0, d_r[QB]})
             && (ovf_r[QB][1] || rem_r[QB][1] < {1'b0, d_r[QB]})
             && (ovf_r[QB][2] || rem_r[QB][2] < {1'b0, d_r[QB]}))
    else $error("final remainder not below divisor");

  a_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(v_r[QB]))
    else $error("output valid unknown");

endmodule

/* rtl/rod_element_stiffness.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rod_element_stiffness
// Two-node truss bar stiffness terms p*c*c, p*c*s, p*s*s in fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is taken every clock cycle and busy stays
// low. The result of a transaction is on the out_ ports, with out_strobe
// high, for one cycle; results leave in order and cannot be held off. A
// transaction passes through the 50-stage bit-per-stage square root of the
// length and the 64-stage divider that forms the three terms, plus eight
// register stages for input capture, differences, squares, the length sum,
// partial products, their sums, the divider precheck and output clipping.
module rod_element_stiffness (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [15:0]          in_elem_id,
  input  logic signed [31:0]   in_start_x,
  input  logic signed [31:0]   in_start_y,
  input  logic signed [31:0]   in_end_x,
  input  logic signed [31:0]   in_end_y,
  input  logic [31:0]          in_young_modulus,
  input  logic [31:0]          in_cross_area,
  output logic                 out_strobe,
  output logic [15:0]          out_elem_id,
  output logic [62:0]          out_k_cc,
  output logic signed [63:0]   out_k_cs,
  output logic [62:0]          out_k_ss,
  output logic                 out_zero_length,
  output logic                 out_saturated
);

  localparam int CRD_W = rodes_pkg::CRD_W;
  localparam int AX_W  = rodes_pkg::AX_W;
  localparam int U_W   = rodes_pkg::U_W;
  localparam int S_W   = rodes_pkg::S_W;
  localparam int X_W   = rodes_pkg::X_W;
  localparam int TW    = X_W + 1;
  localparam int SQ_W  = rodes_pkg::SQ_W;
  localparam int D_W   = rodes_pkg::D_W;
  localparam int EA_W  = rodes_pkg::EA_W;
  localparam int N_W   = rodes_pkg::N_W;
  localparam int NL    = rodes_pkg::NL;
  localparam int QB    = rodes_pkg::QB;
  localparam int PA_W  = rodes_pkg::PA_W;
  localparam int PB_W  = rodes_pkg::PB_W;
  localparam int PS_W  = rodes_pkg::PS_W;
  localparam int LEN_FRAC = rodes_pkg::LEN_FRAC;

  assign busy = 1'b0;

  // stage 1: input capture
  logic                 v1_r;
  logic [15:0]          id1_r;
  logic [CRD_W-1:0]     sx1_r, sy1_r, ex1_r, ey1_r, e1_r, a1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    id1_r <= in_elem_id;
    sx1_r <= in_start_x;
    sy1_r <= in_start_y;
    ex1_r <= in_end_x;
    ey1_r <= in_end_y;
    e1_r  <= in_young_modulus;
    a1_r  <= in_cross_area;
  end

  // stage 2: differences and magnitudes
  logic                 v2_r;
  rodes_pkg::side_t     side2_r, side2_nxt;
  logic [AX_W-1:0]      ax2_r, ax2_nxt, ay2_r, ay2_nxt;
  logic [CRD_W-1:0]     e2_r, a2_r;
  logic [AX_W-1:0]      dx, dy;

  always_comb begin
    dx             = {ex1_r[CRD_W-1], ex1_r} - {sx1_r[CRD_W-1], sx1_r};
    dy             = {ey1_r[CRD_W-1], ey1_r} - {sy1_r[CRD_W-1], sy1_r};
    ax2_nxt        = dx[AX_W-1] ? (~dx + 1'b1) : dx;
    ay2_nxt        = dy[AX_W-1] ? (~dy + 1'b1) : dy;
    side2_nxt.id   = id1_r;
    side2_nxt.zero = (dx == '0) && (dy == '0);
    side2_nxt.neg  = dx[AX_W-1] != dy[AX_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    side2_r <= side2_nxt;
    ax2_r   <= ax2_nxt;
    ay2_r   <= ay2_nxt;
    e2_r    <= e1_r;
    a2_r    <= a1_r;
  end

  // stage 3: squares, cross product, e*a
  logic                 v3_r;
  rodes_pkg::side_t     side3_r;
  logic [U_W-1:0]       xx3_r, xx3_nxt, yy3_r, yy3_nxt, xy3_r, xy3_nxt;
  logic [EA_W-1:0]      ea3_r, ea3_nxt;

  assign xx3_nxt = ax2_r * ax2_r;
  assign yy3_nxt = ay2_r * ay2_r;
  assign xy3_nxt = ax2_r * ay2_r;
  assign ea3_nxt = e2_r * a2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    side3_r <= side2_r;
    xx3_r   <= xx3_nxt;
    yy3_r   <= yy3_nxt;
    xy3_r   <= xy3_nxt;
    ea3_r   <= ea3_nxt;
  end

  // square root pipeline, entry 0 holds the squared length
  logic                 sq_v_r      [SQ_W+1];
  logic                 sq_v_nxt    [SQ_W+1];
  rodes_pkg::sqp_t      sq_p_r      [SQ_W+1];
  rodes_pkg::sqp_t      sq_p_nxt    [SQ_W+1];
  logic [SQ_W-1:0]      sq_root_r   [SQ_W+1];
  logic [SQ_W-1:0]      sq_root_nxt [SQ_W+1];
  logic [X_W-1:0]       sq_rem_r    [SQ_W+1];
  logic [X_W-1:0]       sq_rem_nxt  [SQ_W+1];

  assign sq_v_nxt[0]      = v3_r;
  assign sq_p_nxt[0].side = side3_r;
  assign sq_p_nxt[0].s    = {1'b0, xx3_r} + {1'b0, yy3_r};
  assign sq_p_nxt[0].xx   = xx3_r;
  assign sq_p_nxt[0].yy   = yy3_r;
  assign sq_p_nxt[0].xy   = xy3_r;
  assign sq_p_nxt[0].ea   = ea3_r;
  assign sq_root_nxt[0]   = '0;
  assign sq_rem_nxt[0]    = {sq_p_nxt[0].s, {(2*LEN_FRAC){1'b0}}};

  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    localparam int B = SQ_W - 1 - k;
    logic [TW-1:0] trial;
    logic [TW-1:0] diff;
    logic          ge;
    assign trial = ({{(TW-SQ_W){1'b0}}, sq_root_r[k]} << (B + 1)) + (TW'(1) << (2 * B));
    assign ge    = {1'b0, sq_rem_r[k]} >= trial;
    assign diff  = {1'b0, sq_rem_r[k]} - trial;
    assign sq_v_nxt[k+1]    = sq_v_r[k];
    assign sq_p_nxt[k+1]    = sq_p_r[k];
    assign sq_rem_nxt[k+1]  = ge ? diff[X_W-1:0] : sq_rem_r[k];
    assign sq_root_nxt[k+1] = ge ? (sq_root_r[k] | (SQ_W'(1) << B)) : sq_root_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SQ_W; k++) sq_v_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k <= SQ_W; k++) sq_v_r[k] <= sq_v_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= SQ_W; k++) begin
      sq_p_r[k]    <= sq_p_nxt[k];
      sq_root_r[k] <= sq_root_nxt[k];
      sq_rem_r[k]  <= sq_rem_nxt[k];
    end
  end

  // stage 5: partial products of the divisor and the three numerators
  logic                 v5_r;
  rodes_pkg::side_t     side5_r;
  rodes_pkg::pp_t       ppd5_r, ppd5_nxt;
  rodes_pkg::pp_t       ppn5_r   [NL];
  rodes_pkg::pp_t       ppn5_nxt [NL];
  rodes_pkg::sqp_t      sqo;
  logic [U_W-1:0]       u_sel    [NL];

  assign sqo             = sq_p_r[SQ_W];
  assign u_sel[rodes_pkg::LN_CC] = sqo.xx;
  assign u_sel[rodes_pkg::LN_CS] = sqo.xy;
  assign u_sel[rodes_pkg::LN_SS] = sqo.yy;
  assign ppd5_nxt = rodes_pkg::pp_mul({{(PA_W-S_W){1'b0}}, sqo.s},
                                      {{(PB_W-SQ_W){1'b0}}, sq_root_r[SQ_W]});

  for (genvar l = 0; l < NL; l++) begin : g_pp
    assign ppn5_nxt[l] = rodes_pkg::pp_mul({{(PA_W-U_W){1'b0}}, u_sel[l]},
                                           {{(PB_W-EA_W){1'b0}}, sqo.ea});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= sq_v_r[SQ_W];
  end

  always_ff @(posedge clk) begin
    side5_r <= sqo.side;
    ppd5_r  <= ppd5_nxt;
    for (int l = 0; l < NL; l++) ppn5_r[l] <= ppn5_nxt[l];
  end

  // stage 6: partial product sums
  logic                 v6_r;
  rodes_pkg::side_t     side6_r;
  logic [D_W-1:0]       d6_r;
  rodes_pkg::num_t      num6_r, num6_nxt;
  logic [PS_W-1:0]      dsum;
  logic [PS_W-1:0]      nsum [NL];

  assign dsum = rodes_pkg::pp_sum(ppd5_r);
  for (genvar l = 0; l < NL; l++) begin : g_sum
    assign nsum[l]     = rodes_pkg::pp_sum(ppn5_r[l]);
    assign num6_nxt[l] = nsum[l][N_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    side6_r <= side5_r;
    d6_r    <= dsum[D_W-1:0];
    num6_r  <= num6_nxt;
  end

  // division
  logic                 dv_valid;
  rodes_pkg::side_t     dv_side;
  rodes_pkg::quo_t      dv_quo;
  logic [NL-1:0]        dv_ovf;
  rodes_pkg::side_t     dv_side_in;

  assign dv_side_in = side6_r;

  rodes_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v6_r),
    .in_side   (dv_side_in),
    .in_d      (d6_r),
    .in_num    (num6_r),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_quo   (dv_quo),
    .out_ovf   (dv_ovf)
  );

  // output stage: clipping and sign
  logic [QB-1:0]        lim   [NL];
  logic [QB-1:0]        mag   [NL];
  logic [NL-1:0]        clip;
  logic                 out_strobe_r;
  logic [15:0]          out_elem_id_r;
  logic [62:0]          out_k_cc_r, out_k_cc_nxt, out_k_ss_r, out_k_ss_nxt;
  logic [63:0]          out_k_cs_r, out_k_cs_nxt;
  logic                 out_zero_length_r;
  logic                 out_saturated_r, out_saturated_nxt;

  for (genvar l = 0; l < NL; l++) begin : g_clip
    assign lim[l]  = (l == rodes_pkg::LN_CS && dv_side.neg) ? rodes_pkg::NEG_LIM
                                                            : rodes_pkg::POS_LIM;
    assign clip[l] = !dv_side.zero && (dv_ovf[l] || dv_quo[l] > lim[l]);
    assign mag[l]  = dv_side.zero ? '0 : (clip[l] ? lim[l] : dv_quo[l]);
  end

  always_comb begin
    out_k_cc_nxt      = mag[rodes_pkg::LN_CC][62:0];
    out_k_ss_nxt      = mag[rodes_pkg::LN_SS][62:0];
    out_k_cs_nxt      = dv_side.neg ? (~mag[rodes_pkg::LN_CS] + 1'b1) : mag[rodes_pkg::LN_CS];
    out_saturated_nxt = |clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= dv_valid;
  end

  always_ff @(posedge clk) begin
    out_elem_id_r     <= dv_side.id;
    out_k_cc_r        <= out_k_cc_nxt;
    out_k_cs_r        <= out_k_cs_nxt;
    out_k_ss_r        <= out_k_ss_nxt;
    out_zero_length_r <= dv_side.zero;
    out_saturated_r   <= out_saturated_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_elem_id     = out_elem_id_r;
  assign out_k_cc        = out_k_cc_r;
  assign out_k_cs        = out_k_cs_r;
  assign out_k_ss        = out_k_ss_r;
  assign out_zero_length = out_zero_length_r;
  assign out_saturated   = out_saturated_r;

  a_zero_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_zero_length && out_saturated))
    else $error("zero length transaction flagged saturated");

  a_zero_terms: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_zero_length |-> out_k_cc == '0 && out_k_cs == '0 && out_k_ss == '0)
    else $error("zero length transaction with nonzero terms");

  a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v_r[SQ_W] |-> sq_rem_r[SQ_W] <= {{(X_W-SQ_W-1){1'b0}}, sq_root_r[SQ_W], 1'b0})
    else $error("square root remainder out of range");

endmodule

/* tb/rod_element_stiffness_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rod_element_stiffness_tb
// Self-checking bench for the truss bar stiffness pipeline. A driver feeds
// element transactions from a queue with random gaps; a monitor compares each
// strobed result against terms computed here with wide exact integer math.
// ----------------------------------------------------------------------------
module rod_element_stiffness_tb;

  localparam int FRAC  = 16;
  localparam int LFRAC = 16;
  localparam int LATENCY = 121;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [15:0] id;
    logic [31:0] sx, sy, ex, ey;
    logic [31:0] e_mod, area;
  } elem_t;

  typedef struct {
    logic [15:0] id;
    logic [62:0] cc;
    logic [63:0] cs;
    logic [62:0] ss;
    logic        zero;
    logic        sat;
  } terms_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_elem_id = '0;
  logic signed [31:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic [31:0] in_young_modulus = '0, in_cross_area = '0;
  logic out_strobe;
  logic [15:0] out_elem_id;
  logic [62:0] out_k_cc, out_k_ss;
  logic signed [63:0] out_k_cs;
  logic out_zero_length, out_saturated;

  elem_t  pending_elems[$];
  terms_t expected_terms[$];
  int errors = 0;
  int n_sent = 0, n_checked = 0, n_zero = 0, n_sat = 0;
  int cycles = 0;
  int gap = 0;

  rod_element_stiffness DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_elem_id(in_elem_id), .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .in_young_modulus(in_young_modulus), .in_cross_area(in_cross_area),
    .out_strobe(out_strobe), .out_elem_id(out_elem_id), .out_k_cc(out_k_cc),
    .out_k_cs(out_k_cs), .out_k_ss(out_k_ss), .out_zero_length(out_zero_length),
    .out_saturated(out_saturated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] clip_term(logic [255:0] q, logic [63:0] lim,
                                            inout logic sat);
    if (q > {192'd0, lim}) begin
      sat = 1'b1;
      return lim;
    end
    return q[63:0];
  endfunction

  function automatic terms_t bar_terms(elem_t e);
    terms_t t;
    logic signed [32:0] dx, dy;
    logic [32:0] ax, ay;
    logic [255:0] xx, yy, xy, s, sx, d, ea, r, q;
    logic [63:0] lg, mag;
    logic neg, sat;
    dx = $signed({e.ex[31], e.ex}) - $signed({e.sx[31], e.sx});
    dy = $signed({e.ey[31], e.ey}) - $signed({e.sy[31], e.sy});
    ax = dx[32] ? -dx : dx;
    ay = dy[32] ? -dy : dy;
    t.id = e.id;
    t.cc = '0;
    t.cs = '0;
    t.ss = '0;
    t.zero = (ax == 0) && (ay == 0);
    sat = 1'b0;
    if (!t.zero) begin
      xx = ax * ax;
      yy = ay * ay;
      xy = ax * ay;
      s = xx + yy;
      sx = s << (2 * LFRAC);
      lg = '0;
      for (int b = 63; b >= 0; b--) begin
        r = {192'd0, lg | (64'd1 << b)};
        if (r * r <= sx) lg = r[63:0];
      end
      d = s * lg;
      ea = (e.e_mod * e.area) << (FRAC + LFRAC);
      neg = dx[32] != dy[32] && ax != 0 && ay != 0;
      q = (ea * xx) / d;
      mag = clip_term(q, {1'b0, {63{1'b1}}}, sat);
      t.cc = mag[62:0];
      q = (ea * yy) / d;
      mag = clip_term(q, {1'b0, {63{1'b1}}}, sat);
      t.ss = mag[62:0];
      q = (ea * xy) / d;
      mag = clip_term(q, neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}, sat);
      t.cs = neg ? -mag : mag;
    end
    t.sat = sat;
    return t;
  endfunction

  function automatic logic [31:0] rand_word(int kind);
    case (kind)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 255) << 16;
      3: return $urandom_range(0, 40) - 20;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_elem(logic [15:0] id, logic [31:0] sx, sy, ex, ey, em, ar);
    elem_t e;
    e.id = id; e.sx = sx; e.sy = sy; e.ex = ex; e.ey = ey; e.e_mod = em; e.area = ar;
    pending_elems.push_back(e);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && start && !busy) begin
      n_sent++;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
    end
    if (!rst_n || pending_elems.size() == 0) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (gap > 0) begin
      gap--;
      start <= 1'b0;
    end else begin
      elem_t e;
      e = pending_elems.pop_front();
      expected_terms.push_back(bar_terms(e));
      in_elem_id <= e.id;
      in_start_x <= e.sx;
      in_start_y <= e.sy;
      in_end_x <= e.ex;
      in_end_y <= e.ey;
      in_young_modulus <= e.e_mod;
      in_cross_area <= e.area;
      start <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_strobe) begin
      if (expected_terms.size() == 0) begin
        $display("%0t: unexpected transaction id %h", $time, out_elem_id);
        errors++;
      end else begin
        terms_t x;
        x = expected_terms.pop_front();
        n_checked++;
        if (x.zero) n_zero++;
        if (x.sat) n_sat++;
        if (out_elem_id !== x.id)
          $display("%0t: elem_id exp %h got %h", $time, x.id, out_elem_id);
        if (out_k_cc !== x.cc)
          $display("%0t: k_cc exp %h got %h", $time, x.cc, out_k_cc);
        if (out_k_cs !== x.cs)
          $display("%0t: k_cs exp %h got %h", $time, x.cs, out_k_cs);
        if (out_k_ss !== x.ss)
          $display("%0t: k_ss exp %h got %h", $time, x.ss, out_k_ss);
        if (out_zero_length !== x.zero)
          $display("%0t: zero_length exp %b got %b", $time, x.zero, out_zero_length);
        if (out_saturated !== x.sat)
          $display("%0t: saturated exp %b got %b", $time, x.sat, out_saturated);
        if (out_elem_id !== x.id || out_k_cc !== x.cc || out_k_cs !== x.cs ||
            out_k_ss !== x.ss || out_zero_length !== x.zero || out_saturated !== x.sat)
          errors++;
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d transactions outstanding", $time,
               expected_terms.size() + pending_elems.size());
      $display("FAIL rod_element_stiffness");
      $finish;
    end
  end

  initial begin
    logic [31:0] bx, by;
    // directed elements
    push_elem(16'h0000, 0, 0, 32'h0001_0000, 0, 200, 32'h0001_0000);
    push_elem(16'hFFFF, 0, 0, 0, 32'h0001_0000, 200, 32'h0001_0000);
    push_elem(16'h0001, 0, 0, 32'h0003_0000, 32'h0004_0000, 1000, 32'h0002_0000);
    push_elem(16'h0002, 0, 0, 32'hFFFD_0000, 32'h0004_0000, 1000, 32'h0002_0000);
    push_elem(16'h0003, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
              1000, 32'h0001_0000);
    push_elem(16'h0004, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_elem(16'h0005, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000);
    push_elem(16'h0006, 0, 0, 32'h0001_0000, 32'h0001_0000, 500, 0);
    push_elem(16'h0007, 0, 0, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_elem(16'h0008, 0, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_elem(16'h0009, 0, 0, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_elem(16'h000A, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_elem(16'h000B, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              1, 1);
    push_elem(16'h000C, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'hFFFF_FFFF, 1);
    push_elem(16'h000D, 0, 0, 32'h8000_0000, 1, 7, 32'h8000_0000);
    push_elem(16'h000E, 32'h1234_0000, 32'h1234_0000, 32'h1234_0000, 32'hEDCC_0000,
              210000, 32'h0000_8000);
    // random elements
    for (int i = 0; i < 950; i++) begin
      bx = rand_word($urandom_range(0, 4));
      by = rand_word($urandom_range(0, 4));
      if ($urandom_range(0, 19) == 0)
        push_elem($urandom(), bx, by, bx, by, $urandom(), $urandom());
      else
        push_elem($urandom(), bx, by,
                  ($urandom_range(0, 1) ? bx + rand_word(3 + $urandom_range(0, 1))
                                        : rand_word($urandom_range(0, 4))),
                  ($urandom_range(0, 1) ? by + rand_word(3 + $urandom_range(0, 1))
                                        : rand_word($urandom_range(0, 4))),
                  ($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 300000)),
                  ($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0010_0000)));
    end
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (pending_elems.size() == 0 && !start && expected_terms.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("checked %0d of %0d bar elements, %0d zero length, %0d saturated",
             n_checked, n_sent, n_zero, n_sat);
    if (errors == 0) begin
      $display("PASS rod_element_stiffness");
    end else begin
      $display("FAIL rod_element_stiffness");
    end
    $finish;
  end

endmodule
